FILE: hdl/websocket_frame_deframer_macros.svh
// Assertion helpers used by the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Checked only while out of reset.
`define WSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define WSFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/wsfd_pkg.sv
`default_nettype none
package wsfd_pkg;

  // Length codes in the 7-bit length field of header byte 1
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  // Extended length bytes still due after the first one
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;

  localparam logic [1:0] KEY_LAST_IDX = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
    logic       final_fragment;
    logic [2:0] reserved_bits;
    logic [3:0] frame_opcode;
    logic       was_masked;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hdl/wsfd_chan.sv
`default_nettype none
interface wsfd_chan #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/wsfd_in_stage.sv
`default_nettype none
module wsfd_in_stage
  import wsfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_ready,
  output logic          stg_valid,
  output in_item_t      stg_item,
  input  wire logic     stg_take
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Slot frees up in the same cycle the parser takes it
  assign in_ready  = !valid_r || stg_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule
`default_nettype wire

FILE: hdl/wsfd_parser.sv
`default_nettype none
module wsfd_parser
  import wsfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] raw_byte,
  output logic            res_valid,
  output out_item_t       res_item
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [2:0]  ext_r, ext_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;

  logic [7:0]  key_byte;
  logic [63:0] rem_shift;
  logic        res_last;
  logic        res_empty;
  logic [7:0]  res_data;

  // Key byte 0 is the first received, kept in the top byte
  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign rem_shift = {rem_r[55:0], raw_byte};

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    mask_nxt  = mask_r;
    rem_nxt   = rem_r;
    ext_nxt   = ext_r;
    key_nxt   = key_r;
    kidx_nxt  = kidx_r;
    res_valid = 1'b0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    res_data  = '0;
    case (phase_r)
      PH_HDR1: begin
        mask_nxt = raw_byte[7];
        rem_nxt  = '0;
        if (raw_byte[6:0] == LEN16_CODE) begin
          ext_nxt   = EXT16_LEFT;
          phase_nxt = PH_EXTLEN;
        end else if (raw_byte[6:0] == LEN64_CODE) begin
          ext_nxt   = EXT64_LEFT;
          phase_nxt = PH_EXTLEN;
        end else begin
          rem_nxt  = {57'd0, raw_byte[6:0]};
          kidx_nxt = '0;
          if (raw_byte[7]) begin
            phase_nxt = PH_KEY;
          end else if (raw_byte[6:0] == 7'd0) begin
            phase_nxt = PH_HDR0;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_EXTLEN: begin
        rem_nxt = rem_shift;
        if (ext_r == 3'd0) begin
          kidx_nxt = '0;
          if (mask_r) begin
            phase_nxt = PH_KEY;
          end else if (rem_shift == 64'd0) begin
            phase_nxt = PH_HDR0;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else begin
          ext_nxt = ext_r - 3'd1;
        end
      end
      PH_KEY: begin
        case (kidx_r)
          2'd0:    key_nxt[31:24] = raw_byte;
          2'd1:    key_nxt[23:16] = raw_byte;
          2'd2:    key_nxt[15:8]  = raw_byte;
          default: key_nxt[7:0]   = raw_byte;
        endcase
        kidx_nxt = kidx_r + 2'd1;
        if (kidx_r == KEY_LAST_IDX) begin
          if (rem_r == 64'd0) begin
            phase_nxt = PH_HDR0;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        kidx_nxt  = kidx_r + 2'd1;
        rem_nxt   = rem_r - 64'd1;
        res_valid = 1'b1;
        res_data  = raw_byte ^ key_byte;
        res_last  = (rem_r == 64'd1);
        if (rem_r == 64'd1) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        hdr_nxt   = raw_byte;
        key_nxt   = '0;
        kidx_nxt  = '0;
        rem_nxt   = '0;
        ext_nxt   = '0;
        phase_nxt = PH_HDR1;
      end
    endcase
  end

  always_comb begin
    res_item.payload_byte   = res_data;
    res_item.last_of_frame  = res_last;
    res_item.empty_frame    = res_empty;
    res_item.final_fragment = hdr_r[7];
    res_item.reserved_bits  = hdr_r[6:4];
    res_item.frame_opcode   = hdr_r[3:0];
    res_item.was_masked     = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hdr_r   <= '0;
      mask_r  <= 1'b0;
      rem_r   <= '0;
      ext_r   <= '0;
      key_r   <= '0;
      kidx_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      mask_r  <= mask_nxt;
      rem_r   <= rem_nxt;
      ext_r   <= ext_nxt;
      key_r   <= key_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/wsfd_out_stage.sv
`default_nettype none
module wsfd_out_stage
  import wsfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_item_t res_item,
  output logic           can_load,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      out_ready
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

FILE: hdl/websocket_frame_deframer.sv
// WebSocket (RFC 6455) frame deframer.
// in_chan carries the raw frame stream, one byte per item. Frames follow one
// another with no gap: two header bytes, 2 or 8 extended length bytes when
// the 7-bit length is 126 or 127, four masking key bytes when MASK is set,
// then the payload. Header, length and key bytes give no result.
// out_chan gives one item per payload byte, unmasked, tagged with the frame's
// FIN, RSV and opcode fields, the mask bit and a last-of-frame flag. A frame
// of zero length gives a single empty marker item (payload 0, last set).
// A byte taken from in_chan passes the input register, the parser and the
// output register, in that order, before its result shows on out_chan.
// Throughput: one byte per cycle while out_chan is not stalled; the parser
// is a single pass of logic between the input register and the output
// register, with the 64-bit length down-counter as its longest path.
// Stalls: while out_chan is held off with a result pending, the parser stops
// and the input register holds one more byte, then in_chan.ready drops.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to the first header byte of a new frame.
`default_nettype none
module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  wsfd_chan.sink    in_chan,
  wsfd_chan.source  out_chan
);

  logic      stg_valid;
  in_item_t  stg_item;
  logic      can_load;
  logic      fire;
  logic      res_valid;
  out_item_t res_item;

  // Input register: decouples in_chan from the parser
  wsfd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_item   (in_chan.data),
    .in_ready  (in_chan.ready),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_take  (fire)
  );

  // A staged byte is parsed whenever the output register can take a result
  assign fire = stg_valid && can_load;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .raw_byte  (stg_item.in_byte),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // Output register: holds a result while out_chan stalls
  wsfd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_valid),
    .res_item  (res_item),
    .can_load  (can_load),
    .out_valid (out_chan.valid),
    .out_item  (out_chan.data),
    .out_ready (out_chan.ready)
  );

endmodule
`default_nettype wire

FILE: hdl/wsfd_checker.sv
`default_nettype none
`include "websocket_frame_deframer_macros.svh"
module wsfd_checker
  import wsfd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  `WSFD_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result pending after reset")
  `WSFD_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid, "result dropped in stall")
  `WSFD_ASSERT(a_stall_stable, out_valid && !out_ready |=> $stable(out_item), "result changed in stall")
  `WSFD_ASSERT(a_empty_marker, out_valid && out_item.empty_frame |-> out_item.last_of_frame && out_item.payload_byte == 8'd0, "bad empty marker")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.data)
);
`default_nettype wire
